@@ hw/rtl/two_class_fifo_oldest_first_unit_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TFO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TFO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tfo_pkg.sv @@
package tfo_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int STAMP_W     = 32;
    localparam int ENTRY_W     = ID_W + STAMP_W;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ID_W-1:0]    id_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    typedef enum logic [1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_DEQ_ANY  = 2'd1,
        OP_DEQ_CAT  = 2'd2,
        OP_DEQ_DOG  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CAT  = 2'd0,
        KIND_DOG  = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_ENQUEUED  = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELIVERED = 3'd3,
        ST_NONE      = 3'd4
    } status_t;

    // Command from the sequencer to one queue.
    typedef struct packed {
        logic push;
        logic pop;
    } q_cmd_t;

    // Occupancy flags of one queue before the current request.
    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } q_stat_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

@@ hw/rtl/tfo_ram.sv @@
module tfo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/tfo_queue.sv @@
module tfo_queue
    import tfo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_cmd_t  cmd,
    input  id_t     wr_id,
    input  stamp_t  wr_stamp,
    output id_t     head_id,
    output stamp_t  head_stamp,
    output q_stat_t stat
);

    ptr_t head_reg, head_next;
    ptr_t tail_reg, tail_next;
    cnt_t count_reg, count_next;
    logic [ENTRY_W-1:0] rd_data;

    // The head entry is read every cycle, so it is ready in the next cycle.
    tfo_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (cmd.push),
        .waddr(tail_reg),
        .wdata({wr_id, wr_stamp}),
        .raddr(head_reg),
        .rdata(rd_data)
    );

    assign head_id    = rd_data[ENTRY_W-1:STAMP_W];
    assign head_stamp = rd_data[STAMP_W-1:0];

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.last  = (count_reg == CNT_W'(1));

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tail_next  = next_ptr(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            head_next  = next_ptr(head_reg);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/two_class_fifo_oldest_first_unit.sv @@
// Channel   Ports                                        Handshake
// request   opcode, animal_kind, animal_id               start high while busy low
// result    status, out_kind, out_id, out_stamp,         done high for one cycle
//           cats_empty, dogs_empty
//
// Every request passes from acceptance through the execute state to its result,
// and a new request can be accepted in the cycle that shows the previous result;
// the block does not accept a new request while it executes one. The queue
// memories have a registered read: the head entries are read at the
// acceptance edge and used in the following execute cycle.
// Reset clears pointers, counts, the arrival counter and the sequencer; the
// memories keep no reset. The receiver cannot stall, so done is a pure strobe.
module two_class_fifo_oldest_first_unit
    import tfo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [1:0]  animal_kind,
    input  logic [31:0] animal_id,
    output logic        done,
    output logic [2:0]  status,
    output logic [1:0]  out_kind,
    output logic [31:0] out_id,
    output logic [31:0] out_stamp,
    output logic        cats_empty,
    output logic        dogs_empty
);

    // The sequencer is idle until a request arrives, then executes it in S_EXEC
    // while the memories present the head entries.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Captured request.
    op_t  op_reg;
    logic [1:0] kind_reg;
    id_t  id_reg;

    stamp_t counter_reg, counter_next;

    // Result registers.
    logic    done_reg, done_next;
    status_t status_reg, status_next;
    kind_t   out_kind_reg, out_kind_next;
    id_t     out_id_reg, out_id_next;
    stamp_t  out_stamp_reg, out_stamp_next;
    logic    cats_empty_reg, cats_empty_next;
    logic    dogs_empty_reg, dogs_empty_next;

    q_cmd_t  cat_cmd, dog_cmd;
    q_stat_t cat_stat, dog_stat;
    id_t     cat_head_id, dog_head_id;
    stamp_t  cat_head_stamp, dog_head_stamp;
    stamp_t  stamp_diff;
    logic    pick_cat, pick_dog;
    logic    accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);

    tfo_queue u_cats (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cat_cmd),
        .wr_id     (id_reg),
        .wr_stamp  (counter_reg),
        .head_id   (cat_head_id),
        .head_stamp(cat_head_stamp),
        .stat      (cat_stat)
    );

    tfo_queue u_dogs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dog_cmd),
        .wr_id     (id_reg),
        .wr_stamp  (counter_reg),
        .head_id   (dog_head_id),
        .head_stamp(dog_head_stamp),
        .stat      (dog_stat)
    );

    // The dog head is older when the wrapped stamp difference is negative.
    assign stamp_diff = dog_head_stamp - cat_head_stamp;

    always_comb
    begin
        state_next      = state_reg;
        counter_next    = counter_reg;
        done_next       = 1'b0;
        status_next     = ST_NONE;
        out_kind_next   = KIND_NONE;
        out_id_next     = '0;
        out_stamp_next  = '0;
        cat_cmd         = '0;
        dog_cmd         = '0;
        pick_cat        = 1'b0;
        pick_dog        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (op_reg)
                    OP_ENQUEUE:
                    begin
                        // Every enqueue consumes a stamp, even a refused one.
                        counter_next = counter_reg + STAMP_W'(1);
                        if (kind_reg == KIND_CAT)
                        begin
                            if (cat_stat.full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next  = ST_ENQUEUED;
                                cat_cmd.push = 1'b1;
                            end
                        end
                        else if (kind_reg == KIND_DOG)
                        begin
                            if (dog_stat.full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next  = ST_ENQUEUED;
                                dog_cmd.push = 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = ST_REJECTED;
                        end
                    end
                    OP_DEQ_ANY:
                    begin
                        if (cat_stat.empty)
                        begin
                            pick_dog = !dog_stat.empty;
                        end
                        else if (dog_stat.empty)
                        begin
                            pick_cat = 1'b1;
                        end
                        else
                        begin
                            // On equal stamps the cat is delivered.
                            pick_dog = stamp_diff[STAMP_W-1];
                            pick_cat = !stamp_diff[STAMP_W-1];
                        end
                    end
                    OP_DEQ_CAT:
                    begin
                        pick_cat = !cat_stat.empty;
                    end
                    OP_DEQ_DOG:
                    begin
                        pick_dog = !dog_stat.empty;
                    end
                    default:
                    begin
                        status_next = ST_NONE;
                    end
                endcase

                if (pick_cat)
                begin
                    cat_cmd.pop    = 1'b1;
                    status_next    = ST_DELIVERED;
                    out_kind_next  = KIND_CAT;
                    out_id_next    = cat_head_id;
                    out_stamp_next = cat_head_stamp;
                end
                else if (pick_dog)
                begin
                    dog_cmd.pop    = 1'b1;
                    status_next    = ST_DELIVERED;
                    out_kind_next  = KIND_DOG;
                    out_id_next    = dog_head_id;
                    out_stamp_next = dog_head_stamp;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Emptiness after this request, from the occupancy before it.
        cats_empty_next = cat_cmd.push ? 1'b0 :
                          cat_cmd.pop  ? cat_stat.last : cat_stat.empty;
        dogs_empty_next = dog_cmd.push ? 1'b0 :
                          dog_cmd.pop  ? dog_stat.last : dog_stat.empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            counter_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            done_reg    <= done_next;
        end
    end

    // Request capture and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(opcode);
            kind_reg <= animal_kind;
            id_reg   <= animal_id;
        end
        if (done_next)
        begin
            status_reg     <= status_next;
            out_kind_reg   <= out_kind_next;
            out_id_reg     <= out_id_next;
            out_stamp_reg  <= out_stamp_next;
            cats_empty_reg <= cats_empty_next;
            dogs_empty_reg <= dogs_empty_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign out_kind   = out_kind_reg;
    assign out_id     = out_id_reg;
    assign out_stamp  = out_stamp_reg;
    assign cats_empty = cats_empty_reg;
    assign dogs_empty = dogs_empty_reg;

endmodule

@@ hw/rtl/tfo_checker.sv @@
`include "two_class_fifo_oldest_first_unit_defines.svh"

module tfo_checker
    import tfo_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  opcode,
    input logic [1:0]  animal_kind,
    input logic [31:0] animal_id,
    input logic        done,
    input logic [2:0]  status,
    input logic [1:0]  out_kind,
    input logic [31:0] out_id,
    input logic [31:0] out_stamp,
    input logic        cats_empty,
    input logic        dogs_empty
);

    // An accepted request is executed in the next cycle.
    `TFO_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not execute")

    // Execution always ends in exactly one result in the following cycle.
    `TFO_ASSERT_NEXT(a_busy_done, busy, done && !busy, "execution produced no result")

    // A result never appears without a request accepted before its execute cycle.
    `TFO_ASSERT_NOW(a_done_source, done, $past(start && !busy, 2), "result without request")

    // Results without an animal carry the neutral kind, id and stamp.
    `TFO_ASSERT_NOW(a_no_animal, done && status != ST_DELIVERED,
        out_kind == KIND_NONE && out_id == '0 && out_stamp == '0, "stray result fields")

    // A delivery always names the class it came from.
    `TFO_ASSERT_NOW(a_delivered_kind, done && status == ST_DELIVERED,
        out_kind == KIND_CAT || out_kind == KIND_DOG, "delivery without a class")

endmodule

bind two_class_fifo_oldest_first_unit tfo_checker u_tfo_checker (.*);
